@@ hw/rtl/sket_pkg.sv @@
// Shared constants and types of the sorted key endpoint table.
`timescale 1ns / 1ps

package sket_pkg;

  localparam int unsigned TableEntriesDef = 16;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned IdW   = 16;
  localparam int unsigned TypeW = 8;

  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqDelete = 2'd1;
  localparam logic [1:0] ReqModify = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StMismatch = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_new;
  } sket_mem_ctrl_t;

  typedef struct packed {
    logic key_ge;
    logic id_eq;
  } sket_cmp_t;

endpackage

@@ hw/rtl/sket_store.sv @@
// Entry memory with registered read data and the compare against the held request.
`timescale 1ns / 1ps

module sket_store #(
  parameter int unsigned TableEntries = 16,
  parameter int unsigned IdxW = $clog2(TableEntries)
) (
  input  logic                         clk_i,
  input  sket_pkg::sket_mem_ctrl_t     ctrl_i,
  input  logic [IdxW-1:0]              rd_addr_i,
  input  logic [IdxW-1:0]              wr_addr_i,
  input  logic [sket_pkg::KeyW-1:0]    new_key_i,
  input  logic [sket_pkg::IdW-1:0]     new_id_i,
  output sket_pkg::sket_cmp_t          cmp_o
);
  import sket_pkg::*;

  localparam int unsigned EntW = KeyW + IdW;

  logic [EntW-1:0] mem_q [TableEntries];
  logic [EntW-1:0] rdata_q;
  logic [EntW-1:0] wdata;

  assign wdata = ctrl_i.wr_new ? {new_key_i, new_id_i} : rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wdata;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign cmp_o.key_ge = (rdata_q[EntW-1:IdW] >= new_key_i);
  assign cmp_o.id_eq  = (rdata_q[IdW-1:0] == new_id_i);

endmodule

@@ hw/rtl/sorted_key_endpoint_table_top.sv @@
// Top level of the sorted key endpoint table: request sequencer and configuration.
`timescale 1ns / 1ps
// The block keeps up to TableEntries (key, endpoint id) entries in ascending key order.
// A request is taken when start is high and busy is low: insert, delete or modify key.
// The route type register is written through the cfg channel, which is always ready.
// Write it only while no request is in progress; the block itself does not enforce this.
// Each request gives one result, shown for one cycle with done_o high: status,
// position and the entry count after the request. The receiver cannot stall.
// A request first scans all valid entries through the single read port of the
// entry memory, one entry a cycle, then moves the entries between the old and new
// place one a cycle, then writes the new entry for an insert or a modify. A refused
// insert or an unused request code goes from idle straight to the final state,
// with no scan and no move. busy stays high until the result is shown, so one
// request is in progress at a time.
// Reset clears the entry count, the route type and the sequencer; the entry memory
// holds no reset value and is read only below the count.

module sorted_key_endpoint_table_top #(
  parameter int unsigned TableEntries = sket_pkg::TableEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type_i,
  input  logic [sket_pkg::KeyW-1:0]    req_key_i,
  input  logic [sket_pkg::IdW-1:0]     endpoint_id_i,
  input  logic [sket_pkg::TypeW-1:0]   endpoint_type_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [3:0]                   position_o,
  output logic [4:0]                   entry_count_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sket_pkg::TypeW-1:0]   cfg_data_i
);
  import sket_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StPlan  = 3'd2;
  localparam logic [2:0] StShift = 3'd3;
  localparam logic [2:0] StFinal = 3'd4;

  logic [2:0]       st_q, st_d;
  logic [TypeW-1:0] route_type_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [1:0]       op_q, op_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [CntW-1:0]  sc_q, sc_d;
  logic             rv_q, rv_d;
  logic [IdxW-1:0]  ri_q, ri_d;
  logic [CntW-1:0]  lb_q, lb_d;
  logic [CntW-1:0]  fid_q, fid_d;
  logic             lb_fnd_q, lb_fnd_d;
  logic             fid_fnd_q, fid_fnd_d;
  logic [IdxW-1:0]  rp_q, rp_d;
  logic [CntW-1:0]  moves_q, moves_d;
  logic             up_q, up_d;
  logic             wv_q, wv_d;
  logic [IdxW-1:0]  wa_q, wa_d;
  logic [IdxW-1:0]  target_q, target_d;
  logic             wnew_q, wnew_d;
  logic             inc_q, inc_d;
  logic             dec_q, dec_d;
  logic [1:0]       status_q, status_d;
  logic [3:0]       pos_q, pos_d;
  logic             done_q, done_d;

  logic [CntW-1:0]  cnt_m1;
  logic [CntW-1:0]  fid_p1;
  logic [CntW-1:0]  fid_m1;
  logic [CntW-1:0]  lb_m1;

  sket_mem_ctrl_t   mem_ctrl;
  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  wr_addr;
  sket_cmp_t        cmp;

  assign cnt_m1 = count_q - 1'b1;
  assign fid_p1 = fid_q + 1'b1;
  assign fid_m1 = fid_q - 1'b1;
  assign lb_m1  = lb_q - 1'b1;

  sket_store #(
    .TableEntries(TableEntries),
    .IdxW        (IdxW)
  ) u_store (
    .clk_i    (clk_i),
    .ctrl_i   (mem_ctrl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .new_key_i(key_q),
    .new_id_i (id_q),
    .cmp_o    (cmp)
  );

  always_comb begin
    st_d      = st_q;
    count_d   = count_q;
    op_d      = op_q;
    key_d     = key_q;
    id_d      = id_q;
    sc_d      = sc_q;
    rv_d      = 1'b0;
    ri_d      = ri_q;
    lb_d      = lb_q;
    fid_d     = fid_q;
    lb_fnd_d  = lb_fnd_q;
    fid_fnd_d = fid_fnd_q;
    rp_d      = rp_q;
    moves_d   = moves_q;
    up_d      = up_q;
    wv_d      = 1'b0;
    wa_d      = wa_q;
    target_d  = target_q;
    wnew_d    = wnew_q;
    inc_d     = inc_q;
    dec_d     = dec_q;
    status_d  = status_q;
    pos_d     = pos_q;
    done_d    = 1'b0;
    mem_ctrl  = '0;
    rd_addr   = '0;
    wr_addr   = '0;

    unique case (st_q)
      StIdle: begin
        if (start) begin
          op_d      = req_type_i;
          key_d     = req_key_i;
          id_d      = endpoint_id_i;
          sc_d      = '0;
          lb_d      = count_q;
          fid_d     = count_q;
          lb_fnd_d  = 1'b0;
          fid_fnd_d = 1'b0;
          wnew_d    = 1'b0;
          inc_d     = 1'b0;
          dec_d     = 1'b0;
          status_d  = StOk;
          pos_d     = '0;
          st_d      = StScan;
          case (req_type_i) inside
            ReqInsert: begin
              if (count_q >= CntW'(TableEntries)) begin
                status_d = StFull;
                st_d     = StFinal;
              end else if (endpoint_type_i != route_type_q) begin
                status_d = StMismatch;
                st_d     = StFinal;
              end
            end
            ReqDelete, ReqModify: begin
              st_d = StScan;
            end
            default: begin
              st_d = StFinal;
            end
          endcase
        end
      end
      StScan: begin
        if (sc_q != count_q) begin
          mem_ctrl.rd_en = 1'b1;
          rd_addr        = sc_q[IdxW-1:0];
          ri_d           = sc_q[IdxW-1:0];
          sc_d           = sc_q + 1'b1;
          rv_d           = 1'b1;
        end
        if (rv_q) begin
          if (!lb_fnd_q && cmp.key_ge) begin
            lb_d     = CntW'(ri_q);
            lb_fnd_d = 1'b1;
          end
          if (!fid_fnd_q && cmp.id_eq) begin
            fid_d     = CntW'(ri_q);
            fid_fnd_d = 1'b1;
          end
        end
        if (sc_q == count_q && !rv_q) begin
          st_d = StPlan;
        end
      end
      StPlan: begin
        st_d    = StShift;
        moves_d = '0;
        case (op_q)
          ReqInsert: begin
            up_d     = 1'b1;
            rp_d     = cnt_m1[IdxW-1:0];
            moves_d  = count_q - lb_q;
            target_d = lb_q[IdxW-1:0];
            wnew_d   = 1'b1;
            inc_d    = 1'b1;
            pos_d    = 4'(lb_q);
          end
          ReqDelete: begin
            if (!fid_fnd_q) begin
              status_d = StNotFound;
            end else begin
              up_d    = 1'b0;
              rp_d    = fid_p1[IdxW-1:0];
              moves_d = cnt_m1 - fid_q;
              dec_d   = 1'b1;
              pos_d   = 4'(fid_q);
            end
          end
          default: begin
            if (!fid_fnd_q) begin
              status_d = StNotFound;
            end else if (lb_q > fid_q) begin
              up_d     = 1'b0;
              rp_d     = fid_p1[IdxW-1:0];
              moves_d  = lb_m1 - fid_q;
              target_d = lb_m1[IdxW-1:0];
              wnew_d   = 1'b1;
              pos_d    = 4'(lb_m1);
            end else begin
              up_d     = 1'b1;
              rp_d     = fid_m1[IdxW-1:0];
              moves_d  = fid_q - lb_q;
              target_d = lb_q[IdxW-1:0];
              wnew_d   = 1'b1;
              pos_d    = 4'(lb_q);
            end
          end
        endcase
      end
      StShift: begin
        if (moves_q != '0) begin
          mem_ctrl.rd_en = 1'b1;
          rd_addr        = rp_q;
          moves_d        = moves_q - 1'b1;
          wv_d           = 1'b1;
          if (up_q) begin
            rp_d = rp_q - 1'b1;
            wa_d = rp_q + 1'b1;
          end else begin
            rp_d = rp_q + 1'b1;
            wa_d = rp_q - 1'b1;
          end
        end
        if (wv_q) begin
          mem_ctrl.wr_en = 1'b1;
          wr_addr        = wa_q;
        end
        if (moves_q == '0 && !wv_q) begin
          st_d = StFinal;
        end
      end
      StFinal: begin
        if (wnew_q) begin
          mem_ctrl.wr_en  = 1'b1;
          mem_ctrl.wr_new = 1'b1;
          wr_addr         = target_q;
        end
        if (inc_q) begin
          count_d = count_q + 1'b1;
        end else if (dec_q) begin
          count_d = count_q - 1'b1;
        end
        done_d = 1'b1;
        st_d   = StIdle;
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= StIdle;
      count_q      <= '0;
      route_type_q <= '0;
      rv_q         <= 1'b0;
      wv_q         <= 1'b0;
      done_q       <= 1'b0;
      moves_q      <= '0;
      sc_q         <= '0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      wv_q    <= wv_d;
      done_q  <= done_d;
      moves_q <= moves_d;
      sc_q    <= sc_d;
      if (cfg_valid_i) begin
        route_type_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    id_q      <= id_d;
    ri_q      <= ri_d;
    lb_q      <= lb_d;
    fid_q     <= fid_d;
    lb_fnd_q  <= lb_fnd_d;
    fid_fnd_q <= fid_fnd_d;
    rp_q      <= rp_d;
    up_q      <= up_d;
    wa_q      <= wa_d;
    target_q  <= target_d;
    wnew_q    <= wnew_d;
    inc_q     <= inc_d;
    dec_q     <= dec_d;
    status_q  <= status_d;
    pos_q     <= pos_d;
  end

  assign busy          = (st_q != StIdle);
  assign cfg_ready_o   = 1'b1;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign position_o    = pos_q;
  assign entry_count_o = 5'(count_q);

endmodule

@@ hw/rtl/sket_checker.sv @@
// Port-level checker of the sorted key endpoint table and its bind to the top level.
`timescale 1ns / 1ps

module sket_checker #(
  parameter int unsigned TableEntries = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_i,
  input logic [1:0] status_i,
  input logic [3:0] position_i,
  input logic [4:0] entry_count_i
);
  import sket_pkg::*;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy)
    else $error("Result shown while a request is still in progress.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted request did not raise busy.");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(busy))
    else $error("Result shown without a request in progress.");

  a_error_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && status_i != StOk) |-> (position_i == 4'd0))
    else $error("Refused request reported a nonzero position.");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && status_i == StFull) |-> (entry_count_i == 5'(TableEntries)))
    else $error("Table full reported with a count below capacity.");

endmodule

bind sorted_key_endpoint_table_top sket_checker #(
  .TableEntries(TableEntries)
) u_sket_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_i       (done_o),
  .status_i     (status_o),
  .position_i   (position_o),
  .entry_count_i(entry_count_o)
);
